### rtl/core/double_hash_key_value_map_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double hash key-value map unit
// Shorthand for concurrent checks clocked by clock and reset by reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_KEY_VALUE_MAP_UNIT_MACROS_SVH
`define DOUBLE_HASH_KEY_VALUE_MAP_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define DHKV_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dhkv check failed");

// next-cycle implication, active during reset
`define DHKV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("dhkv check failed");

`endif

### rtl/core/dhkv_pkg.sv
// ----------------------------------------------------------------------------
// dhkv_pkg
// Sizes, codes, command types and hash functions of the key-value map.
// ----------------------------------------------------------------------------
package dhkv_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int LOSE_BITS  = 3;
   localparam int HIGH_SHIFT = 16;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int WORD_W     = KEY_W + VAL_W;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type HALF_SIZE = idx_type'(TABLE_SIZE / 2);
   localparam idx_type LAST_IDX  = idx_type'(TABLE_SIZE - 1);

   localparam logic FUNC_SET = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_ZERO_KEY = 2'd2
   } status_type;

   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic             zero;
      idx_type          pos;
      idx_type          stride;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } ctl_type;

   function automatic idx_type first_slot(input logic [KEY_W-1:0] key);
      return idx_type'((key >> LOSE_BITS) ^ (key >> (2 * LOSE_BITS)));
   endfunction

   function automatic idx_type probe_step(input logic [KEY_W-1:0] key);
      return idx_type'((key >> LOSE_BITS) ^ (key >> HIGH_SHIFT)) | idx_type'(1);
   endfunction

endpackage

### rtl/core/dhkv_ram.sv
// ----------------------------------------------------------------------------
// dhkv_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dhkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dhkv_front.sv
// ----------------------------------------------------------------------------
// dhkv_front
// Accept requests, flag zero keys, hash to first slot and stride, and queue
// them in a two-entry command queue for the probe engine.
// ----------------------------------------------------------------------------
module dhkv_front
   import dhkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_func,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_new_value,
   input  ctl_type          ctl,
   output logic             cmd_valid,
   output cmd_type          cmd
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   cmd_type    new_cmd;

   assign full      = (cnt_ff == 2'd2) | ctl.clearing;
   assign accept    = push & ~full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.func   = req_func;
      new_cmd.key    = req_key;
      new_cmd.value  = req_new_value;
      new_cmd.zero   = (req_key == '0);
      new_cmd.pos    = first_slot(req_key);
      new_cmd.stride = probe_step(req_key);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ ctl.pop;
      cnt_in    = cnt_ff + {1'b0, accept} - {1'b0, ctl.pop};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/core/dhkv_back.sv
// ----------------------------------------------------------------------------
// dhkv_back
// Probe engine: clear the slot memory after reset, walk the probe sequence
// of each command, update the slot, and hold the result for the reader.
// ----------------------------------------------------------------------------
module dhkv_back
   import dhkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output ctl_type          ctl,
   output logic             empty,
   input  logic             pop,
   output logic [VAL_W-1:0] rsp_result_value,
   output logic             rsp_hit,
   output logic [1:0]       rsp_status
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   idx_type          clr_ff, clr_in;
   cmd_type          cur_ff, cur_in;
   idx_type          addr_ff, addr_in;
   idx_type          probe_ff, probe_in;
   idx_type          count_ff, count_in;
   logic [VAL_W-1:0] res_value_ff, res_value_in;
   logic             res_hit_ff, res_hit_in;
   status_type       res_status_ff, res_status_in;
   logic             out_valid_ff, out_valid_in;
   logic [VAL_W-1:0] out_value_ff, out_value_in;
   logic             out_hit_ff, out_hit_in;
   status_type       out_status_ff, out_status_in;

   logic              wr_en, rd_en, out_load;
   idx_type           wr_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic [KEY_W-1:0]  slot_key;
   logic [VAL_W-1:0]  slot_value;

   dhkv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign slot_key   = rd_data[WORD_W-1:VAL_W];
   assign slot_value = rd_data[VAL_W-1:0];
   assign out_load   = (state_ff == ST_DONE) & (~out_valid_ff | pop);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      addr_in       = addr_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      res_value_in  = res_value_ff;
      res_hit_in    = res_hit_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = {cur_ff.key, cur_ff.value};
      rd_en         = 1'b0;
      ctl.pop       = 1'b0;
      ctl.clearing  = (state_ff == ST_CLEAR);
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + idx_type'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               ctl.pop       = 1'b1;
               cur_in        = cmd;
               addr_in       = cmd.pos;
               probe_in      = '0;
               res_value_in  = '0;
               res_hit_in    = 1'b0;
               res_status_in = STATUS_OK;
               if (cmd.zero) begin
                  res_status_in = STATUS_ZERO_KEY;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slot_key == cur_ff.key) begin
               res_hit_in   = 1'b1;
               res_value_in = slot_value;
               wr_en        = (cur_ff.func == FUNC_SET);
               state_in     = ST_DONE;
            end else if (slot_key == '0) begin
               if (cur_ff.func == FUNC_SET) begin
                  if (count_ff >= HALF_SIZE) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + idx_type'(1);
                  end
               end
               state_in = ST_DONE;
            end else if (probe_ff == LAST_IDX) begin
               if (cur_ff.func == FUNC_SET) begin
                  res_status_in = STATUS_FULL;
               end
               state_in = ST_DONE;
            end else begin
               addr_in  = addr_ff + cur_ff.stride;
               probe_in = probe_ff + idx_type'(1);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      out_value_in  = out_value_ff;
      out_hit_in    = out_hit_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff & ~pop;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_value_in  = res_value_ff;
         out_hit_in    = res_hit_ff;
         out_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      addr_ff       <= addr_in;
      probe_ff      <= probe_in;
      res_value_ff  <= res_value_in;
      res_hit_ff    <= res_hit_in;
      res_status_ff <= res_status_in;
      out_value_ff  <= out_value_in;
      out_hit_ff    <= out_hit_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty            = ~out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_status       = out_status_ff;

endmodule

### rtl/core/double_hash_key_value_map_unit.sv
// A request waits in the front queue; the engine steps through IDLE, READ, CHECK
// (READ and CHECK again per extra probe) and DONE into the output register, and a
// zero key goes from IDLE to DONE. One request is finished before another is taken,
// paced by the read-check loop on the single read port of the slot memory. Reset:
// synchronous; then a clearing pass zeroes the key store while full stays high.
// ----------------------------------------------------------------------------
// double_hash_key_value_map_unit
// Open-addressing key-value map with double hashing; a front queue of
// hashed commands feeds a probe engine over one slot memory.
// ----------------------------------------------------------------------------
`include "double_hash_key_value_map_unit_macros.svh"

module double_hash_key_value_map_unit
   import dhkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_func,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_new_value,
   output logic             empty,
   input  logic             pop,
   output logic [VAL_W-1:0] rsp_result_value,
   output logic             rsp_hit,
   output logic [1:0]       rsp_status
);

   ctl_type ctl;
   logic    cmd_valid;
   cmd_type cmd;

   dhkv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_func      (req_func),
      .req_key       (req_key),
      .req_new_value (req_new_value),
      .ctl           (ctl),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   dhkv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .ctl              (ctl),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_value (rsp_result_value),
      .rsp_hit          (rsp_hit),
      .rsp_status       (rsp_status)
   );

   `DHKV_ASSERT_NEXT(a_reset_clears, reset, ctl.clearing)
   `DHKV_ASSERT_IMP(a_full_while_clear, ctl.clearing, full)
   `DHKV_ASSERT_IMP(a_pop_needs_cmd, ctl.pop, cmd_valid)

endmodule
